// ----- src/hsms_pkg.sv -----
// ----------------------------------------------------------------------------
// hsms_pkg: shared types and constants of the humidity sensor sequencer
// Input ops, result kinds, sensor command words, status bits, delays and
// the fixed-point conversion factors.
// ----------------------------------------------------------------------------
package hsms_pkg;

    // Input word kind (tuser on the slave side)
    typedef enum logic [1:0] {
        OP_START_MEAS  = 2'd0,
        OP_START_RESET = 2'd1,
        OP_TICK        = 2'd2,
        OP_XFER_DONE   = 2'd3
    } op_t;

    // Result word kind (tuser on the master side)
    typedef enum logic [2:0] {
        KIND_REQ        = 3'd0,
        KIND_MEAS       = 3'd1,
        KIND_RESET_DONE = 3'd2,
        KIND_CALIB_TO   = 3'd3,
        KIND_BUSY_TO    = 3'd4
    } kind_t;

    // Sensor command bytes, first byte in bits 23..16
    localparam logic [23:0] CMD_STATUS = 24'h710000;
    localparam logic [23:0] CMD_INIT   = 24'hBE0800;
    localparam logic [23:0] CMD_TRIG   = 24'hAC3300;
    localparam logic [23:0] CMD_RESET  = 24'hBA0000;

    // Status byte bits
    localparam int STAT_CAL_BIT  = 3;
    localparam int STAT_BUSY_BIT = 7;

    // Delays in ms
    localparam logic [6:0] CAL_DLY_MS  = 7'd10;
    localparam logic [6:0] MEAS_DLY_MS = 7'd80;
    localparam logic [6:0] RST_DLY_MS  = 7'd20;

    // Conversion: h = raw*10000 >> 20, t = (raw*20000 >> 20) - 5000
    localparam logic [13:0] HUM_SCALE  = 14'd10000;
    localparam logic [14:0] TMP_SCALE  = 15'd20000;
    localparam logic [14:0] TMP_OFFSET = 15'd5000;

    localparam logic [10:0] ELAPSED_MAX = 11'd2047;

    // One result word
    typedef struct packed {
        kind_t              out_kind;
        logic [6:0]         bus_addr;
        logic [1:0]         write_len;
        logic [23:0]        write_bytes;
        logic [2:0]         read_len;
        logic               no_stop;
        logic [13:0]        humidity_centi;
        logic signed [14:0] temperature_centi;
    } result_t;

    function automatic result_t make_req(input logic [6:0]  addr,
                                         input logic [1:0]  wlen,
                                         input logic [23:0] wbytes,
                                         input logic [2:0]  rlen,
                                         input logic        nostop);
        result_t r;
        r             = '0;
        r.out_kind    = KIND_REQ;
        r.bus_addr    = addr;
        r.write_len   = wlen;
        r.write_bytes = wbytes;
        r.read_len    = rlen;
        r.no_stop     = nostop;
        return r;
    endfunction

    function automatic result_t make_kind(input kind_t kind);
        result_t r;
        r          = '0;
        r.out_kind = kind;
        return r;
    endfunction

endpackage

// ----- src/humidity_sensor_measure_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// humidity_sensor_measure_sequencer_unit: I2C readout sequencer
// Timing: a word accepted into the input register is processed
//   combinationally from there, and its result (if any) is registered
//   into the output register that drives m_axis.
// Throughput: one word per cycle while m_axis is ready; a stalled result
//   holds the next word in the input register, and then intake stops.
// Reset (rst_n, async, active low): idle phase, counters clear, both word
//   registers empty, dev_addr = 56, calib_timeout_ms = 100.
// ----------------------------------------------------------------------------
module humidity_sensor_measure_sequencer_unit (
    input  logic        clk,
    input  logic        rst_n,

    // configuration: index 0 dev_addr, index 1 calib_timeout_ms
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [9:0]  cfg_data,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [47:0] read_bytes
    input  logic [1:0]  s_axis_tuser,   // [1:0] op

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [6:0] bus_addr, [8:7] write_len,
                                        // [32:9] write_bytes, [35:33] read_len,
                                        // [36] no_stop, [50:37] humidity_centi,
                                        // [65:51] temperature_centi, [71:66] zero
    output logic [2:0]  m_axis_tuser    // [2:0] out_kind
);
    import hsms_pkg::*;

    localparam logic CFG_DEV_ADDR = 1'b0;
    localparam logic CFG_TIMEOUT  = 1'b1;

    // Sequencer phases; measure phases run from PH_POLL through PH_DATA
    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_POLL      = 4'd1,
        PH_INIT      = 4'd2,
        PH_CAL_DLY   = 4'd3,
        PH_TRIG      = 4'd4,
        PH_MEAS_DLY  = 4'd5,
        PH_BUSY_POLL = 4'd6,
        PH_BUSY_DLY  = 4'd7,
        PH_DATA      = 4'd8,
        PH_RST       = 4'd9,
        PH_RST_DLY   = 4'd10
    } phase_t;

    // ---------------- configuration registers ----------------
    logic [6:0] dev_addr_reg;
    logic [9:0] calib_timeout_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg      <= 7'd56;
            calib_timeout_reg <= 10'd100;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEV_ADDR: dev_addr_reg      <= cfg_data[6:0];
                CFG_TIMEOUT:  calib_timeout_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // ---------------- input register ----------------
    logic        in_valid_reg;
    op_t         in_op_reg;
    logic [47:0] in_bytes_reg;
    logic        out_free;
    logic        item_go;

    // result register
    logic        out_valid_reg;
    result_t     out_reg;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign item_go       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    // payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_op_reg    <= op_t'(s_axis_tuser);
            in_bytes_reg <= s_axis_tdata;
        end
    end

    // ---------------- sequencer state ----------------
    phase_t      phase_reg,   phase_next;
    logic [10:0] elapsed_reg, elapsed_next;
    logic [6:0]  wait_reg,    wait_next;
    logic        retried_reg, retried_next;
    logic        res_valid;
    result_t     res;

    // conversion datapath (two constant multipliers, independent)
    logic [7:0]  status_byte;
    logic [19:0] raw_h, raw_t;
    logic [33:0] h_prod;
    logic [34:0] t_prod;
    logic [14:0] t_floor;
    result_t     meas_res;

    assign status_byte = in_bytes_reg[47:40];
    assign raw_h   = in_bytes_reg[39:20];
    assign raw_t   = in_bytes_reg[19:0];
    assign h_prod  = {14'd0, raw_h} * {20'd0, HUM_SCALE};
    assign t_prod  = {15'd0, raw_t} * {20'd0, TMP_SCALE};
    assign t_floor = t_prod[34:20];

    always_comb
    begin
        meas_res                   = make_kind(KIND_MEAS);
        meas_res.humidity_centi    = h_prod[33:20];
        meas_res.temperature_centi = signed'(t_floor - TMP_OFFSET);
    end

    logic        in_meas;
    logic [10:0] elapsed_tick;
    logic [6:0]  wait_dec;
    logic        is_delay;

    assign in_meas      = (phase_reg >= PH_POLL) && (phase_reg <= PH_DATA);
    assign elapsed_tick = (in_meas && elapsed_reg != ELAPSED_MAX) ?
                          elapsed_reg + 11'd1 : elapsed_reg;
    assign wait_dec     = (wait_reg != 7'd0) ? wait_reg - 7'd1 : 7'd0;
    assign is_delay     = (phase_reg == PH_CAL_DLY) || (phase_reg == PH_MEAS_DLY) ||
                          (phase_reg == PH_BUSY_DLY) || (phase_reg == PH_RST_DLY);

    always_comb
    begin
        phase_next   = phase_reg;
        elapsed_next = elapsed_reg;
        wait_next    = wait_reg;
        retried_next = retried_reg;
        res_valid    = 1'b0;
        res          = '0;

        if (item_go)
        begin
            case (in_op_reg)
                OP_START_MEAS:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        elapsed_next = '0;
                        wait_next    = '0;
                        retried_next = 1'b0;
                        res_valid    = 1'b1;
                        // elapsed restarts at zero: poll unless budget is zero
                        if (calib_timeout_reg != 10'd0)
                        begin
                            phase_next = PH_POLL;
                            res = make_req(dev_addr_reg, 2'd1, CMD_STATUS, 3'd1, 1'b1);
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            res        = make_kind(KIND_CALIB_TO);
                        end
                    end
                end

                OP_START_RESET:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        phase_next = PH_RST;
                        wait_next  = '0;
                        res_valid  = 1'b1;
                        res = make_req(dev_addr_reg, 2'd1, CMD_RESET, 3'd0, 1'b0);
                    end
                end

                OP_TICK:
                begin
                    elapsed_next = elapsed_tick;
                    if (is_delay)
                    begin
                        wait_next = wait_dec;
                        if (wait_dec == 7'd0)
                        begin
                            res_valid = 1'b1;
                            case (phase_reg)
                                PH_CAL_DLY:
                                begin
                                    // budget checked against the updated count
                                    if (elapsed_tick < {1'b0, calib_timeout_reg})
                                    begin
                                        phase_next = PH_POLL;
                                        res = make_req(dev_addr_reg, 2'd1, CMD_STATUS,
                                                       3'd1, 1'b1);
                                    end
                                    else
                                    begin
                                        phase_next = PH_IDLE;
                                        res        = make_kind(KIND_CALIB_TO);
                                    end
                                end
                                PH_RST_DLY:
                                begin
                                    phase_next = PH_IDLE;
                                    res        = make_kind(KIND_RESET_DONE);
                                end
                                default:
                                begin
                                    // measure or busy delay over: poll status
                                    phase_next = PH_BUSY_POLL;
                                    res = make_req(dev_addr_reg, 2'd1, CMD_STATUS,
                                                   3'd1, 1'b1);
                                end
                            endcase
                        end
                    end
                end

                OP_XFER_DONE:
                begin
                    case (phase_reg)
                        PH_POLL:
                        begin
                            res_valid = 1'b1;
                            if (status_byte[STAT_CAL_BIT])
                            begin
                                phase_next = PH_TRIG;
                                res = make_req(dev_addr_reg, 2'd3, CMD_TRIG, 3'd0, 1'b0);
                            end
                            else
                            begin
                                phase_next = PH_INIT;
                                res = make_req(dev_addr_reg, 2'd3, CMD_INIT, 3'd0, 1'b0);
                            end
                        end
                        PH_INIT:
                        begin
                            phase_next = PH_CAL_DLY;
                            wait_next  = CAL_DLY_MS;
                        end
                        PH_TRIG:
                        begin
                            phase_next = PH_MEAS_DLY;
                            wait_next  = MEAS_DLY_MS;
                        end
                        PH_BUSY_POLL:
                        begin
                            if (status_byte[STAT_BUSY_BIT])
                            begin
                                if (retried_reg)
                                begin
                                    phase_next = PH_IDLE;
                                    res_valid  = 1'b1;
                                    res        = make_kind(KIND_BUSY_TO);
                                end
                                else
                                begin
                                    retried_next = 1'b1;
                                    phase_next   = PH_BUSY_DLY;
                                    wait_next    = MEAS_DLY_MS;
                                end
                            end
                            else
                            begin
                                phase_next = PH_DATA;
                                res_valid  = 1'b1;
                                res = make_req(dev_addr_reg, 2'd1, CMD_STATUS, 3'd6, 1'b1);
                            end
                        end
                        PH_DATA:
                        begin
                            phase_next = PH_IDLE;
                            res_valid  = 1'b1;
                            res        = meas_res;
                        end
                        PH_RST:
                        begin
                            phase_next = PH_RST_DLY;
                            wait_next  = RST_DLY_MS;
                        end
                        default: ;  // no transfer outstanding
                    endcase
                end

                default: ;
            endcase
        end
    end

    // state and registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            elapsed_reg   <= '0;
            wait_reg      <= '0;
            retried_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
            wait_reg    <= wait_next;
            retried_reg <= retried_next;
            if (out_free)
            begin
                out_valid_reg <= item_go && res_valid;
                if (item_go && res_valid)
                    out_reg <= res;
            end
        end
    end

    // ---------------- master side ----------------
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.out_kind;
    assign m_axis_tdata  = {6'd0,
                            out_reg.temperature_centi,
                            out_reg.humidity_centi,
                            out_reg.no_stop,
                            out_reg.read_len,
                            out_reg.write_bytes,
                            out_reg.write_len,
                            out_reg.bus_addr};

    // ---------------- assertions ----------------
    a_idle_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> wait_reg == 7'd0)
        else $error("delay count left over in idle");

    a_wait_in_delay: assert property (@(posedge clk) disable iff (!rst_n)
        wait_reg != 7'd0 |-> (phase_reg == PH_CAL_DLY || phase_reg == PH_MEAS_DLY ||
                              phase_reg == PH_BUSY_DLY || phase_reg == PH_RST_DLY))
        else $error("delay count outside a delay phase");

    a_wait_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wait_reg <= MEAS_DLY_MS)
        else $error("delay count above longest delay");

    a_meas_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.out_kind != KIND_MEAS |->
            out_reg.humidity_centi == 14'd0 && out_reg.temperature_centi == 15'sd0)
        else $error("measurement fields set on a non-measurement word");

    a_busy_retry: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_BUSY_DLY |-> retried_reg)
        else $error("busy delay without retry mark");

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: humidity sensor readout sequencer
// Checks the sequencer word by word against a local reckoning of its phases,
// elapsed time and delays. Drives directed sensor sequences first: reset,
// calibration retries and budget, busy retry, output back-pressure. Then
// randomized readout traffic under changing idle patterns.
// ----------------------------------------------------------------------------
module testbench;

    import hsms_pkg::*;

    // register indexes of the configuration port
    localparam logic REG_DEV_ADDR      = 1'b0;
    localparam logic REG_CALIB_TIMEOUT = 1'b1;

    localparam int CYCLE_LIMIT   = 400000;  // far above the slowest correct run
    localparam int SETTLE_CYCLES = 8;       // pipeline depth plus margin
    localparam int DRAIN_LIMIT   = 4000;    // covers the long receiver hold
    localparam int HOLD_CYCLES   = 300;     // receiver hold-off length

    // sequencer phases as this bench tracks them
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_STATUS_POLL,
        PH_INIT,
        PH_CAL_WAIT,
        PH_TRIG,
        PH_MEAS_WAIT,
        PH_BUSY_POLL,
        PH_BUSY_WAIT,
        PH_DATA,
        PH_RESET,
        PH_RESET_WAIT
    } seq_phase_t;

    typedef struct packed {
        seq_phase_t  phase;
        logic [10:0] elapsed;       // ms since measure start, saturating
        logic [6:0]  wait_left;     // ms left in current delay
        logic        busy_retried;
    } seq_state_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [9:0]  cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;     // [47:0] read_bytes
    logic [1:0]  s_axis_tuser = '0;     // [1:0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;          // [6:0] bus_addr, [8:7] write_len,
                                        // [32:9] write_bytes, [35:33] read_len,
                                        // [36] no_stop, [50:37] humidity_centi,
                                        // [65:51] temperature_centi
    logic [2:0]  m_axis_tuser;          // [2:0] out_kind

    // tracked sequencer state and register copies (reset values)
    seq_state_t  seq_st = '{PH_IDLE, 11'd0, 7'd0, 1'b0};
    logic [6:0]  sensor_addr = 7'd56;
    logic [9:0]  calib_budget_ms = 10'd100;

    result_t     outstanding_reports[$];

    int          src_idle_pct = 15;
    int          snk_idle_pct = 51;
    int          hold_request = 0;
    int          hold_left = 0;
    int          error_count = 0;
    int          cycle_count = 0;
    int          words_sent = 0;
    int          words_acted = 0;
    int          reports_due = 0;
    int          reports_checked = 0;
    int          kinds_seen[5] = '{default: 0};

    humidity_sensor_measure_sequencer_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 20 ns period
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t ns: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random ready, or a counted hold-off when a test asks for one.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left = HOLD_CYCLES;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Result builders for the tracked sequencer
    // ------------------------------------------------------------------------
    function automatic result_t bus_request(input logic [1:0]  wlen,
                                            input logic [23:0] wbytes,
                                            input logic [2:0]  rlen,
                                            input logic        nostop);
        result_t r;
        r             = '0;
        r.out_kind    = KIND_REQ;
        r.bus_addr    = sensor_addr;
        r.write_len   = wlen;
        r.write_bytes = wbytes;
        r.read_len    = rlen;
        r.no_stop     = nostop;
        return r;
    endfunction

    function automatic result_t kind_only(input kind_t kind);
        result_t r;
        r          = '0;
        r.out_kind = kind;
        return r;
    endfunction

    // status poll while budget remains, else calibration timeout
    function automatic result_t status_poll_or_timeout();
        if (seq_st.elapsed < 11'(calib_budget_ms))
        begin
            seq_st.phase = PH_STATUS_POLL;
            return bus_request(2'd1, CMD_STATUS, 3'd1, 1'b1);
        end
        seq_st.phase = PH_IDLE;
        return kind_only(KIND_CALIB_TO);
    endfunction

    // ------------------------------------------------------------------------
    // One accepted word through the tracked sequencer; queues the report
    // it causes. acted is low when the word left everything unchanged.
    // ------------------------------------------------------------------------
    task automatic sequence_step(input op_t op, input logic [47:0] rb, output bit acted);
        seq_state_t      prev;
        result_t         res;
        bit              emit;
        logic [7:0]      b0;
        longint unsigned hum;
        longint unsigned tmp;
        prev = seq_st;
        res  = '0;
        emit = 1'b0;
        b0   = rb[47:40];
        case (op)
            OP_START_MEAS:
            begin
                if (seq_st.phase == PH_IDLE)
                begin
                    seq_st.elapsed      = '0;
                    seq_st.wait_left    = '0;
                    seq_st.busy_retried = 1'b0;
                    res  = status_poll_or_timeout();
                    emit = 1'b1;
                end
            end
            OP_START_RESET:
            begin
                if (seq_st.phase == PH_IDLE)
                begin
                    seq_st.phase     = PH_RESET;
                    seq_st.wait_left = '0;
                    res  = bus_request(2'd1, CMD_RESET, 3'd0, 1'b0);
                    emit = 1'b1;
                end
            end
            OP_TICK:
            begin
                // elapsed runs during the whole measurement, saturating
                if (seq_st.phase != PH_IDLE && seq_st.phase != PH_RESET &&
                    seq_st.phase != PH_RESET_WAIT && seq_st.elapsed != ELAPSED_MAX)
                    seq_st.elapsed++;
                if (seq_st.phase inside {PH_CAL_WAIT, PH_MEAS_WAIT, PH_BUSY_WAIT,
                                         PH_RESET_WAIT})
                begin
                    if (seq_st.wait_left != 0)
                        seq_st.wait_left--;
                    if (seq_st.wait_left == 0)
                    begin
                        emit = 1'b1;
                        if (seq_st.phase == PH_CAL_WAIT)
                            res = status_poll_or_timeout();
                        else if (seq_st.phase == PH_RESET_WAIT)
                        begin
                            seq_st.phase = PH_IDLE;
                            res = kind_only(KIND_RESET_DONE);
                        end
                        else
                        begin
                            seq_st.phase = PH_BUSY_POLL;
                            res = bus_request(2'd1, CMD_STATUS, 3'd1, 1'b1);
                        end
                    end
                end
            end
            default:
            begin
                // transfer complete; ignored where nothing is outstanding
                case (seq_st.phase)
                    PH_STATUS_POLL:
                    begin
                        emit = 1'b1;
                        if (b0[STAT_CAL_BIT])
                        begin
                            seq_st.phase = PH_TRIG;
                            res = bus_request(2'd3, CMD_TRIG, 3'd0, 1'b0);
                        end
                        else
                        begin
                            seq_st.phase = PH_INIT;
                            res = bus_request(2'd3, CMD_INIT, 3'd0, 1'b0);
                        end
                    end
                    PH_INIT:
                    begin
                        seq_st.phase     = PH_CAL_WAIT;
                        seq_st.wait_left = CAL_DLY_MS;
                    end
                    PH_TRIG:
                    begin
                        seq_st.phase     = PH_MEAS_WAIT;
                        seq_st.wait_left = MEAS_DLY_MS;
                    end
                    PH_BUSY_POLL:
                    begin
                        if (!b0[STAT_BUSY_BIT])
                        begin
                            seq_st.phase = PH_DATA;
                            res  = bus_request(2'd1, CMD_STATUS, 3'd6, 1'b1);
                            emit = 1'b1;
                        end
                        else if (seq_st.busy_retried)
                        begin
                            seq_st.phase = PH_IDLE;
                            res  = kind_only(KIND_BUSY_TO);
                            emit = 1'b1;
                        end
                        else
                        begin
                            seq_st.busy_retried = 1'b1;
                            seq_st.phase        = PH_BUSY_WAIT;
                            seq_st.wait_left    = MEAS_DLY_MS;
                        end
                    end
                    PH_DATA:
                    begin
                        // raw humidity in bits 39..20, raw temperature in 19..0
                        hum = (64'(rb[39:20]) * 64'(HUM_SCALE)) >> 20;
                        tmp = ((64'(rb[19:0]) * 64'(TMP_SCALE)) >> 20) - 64'(TMP_OFFSET);
                        seq_st.phase          = PH_IDLE;
                        res                   = kind_only(KIND_MEAS);
                        res.humidity_centi    = hum[13:0];
                        res.temperature_centi = tmp[14:0];
                        emit = 1'b1;
                    end
                    PH_RESET:
                    begin
                        seq_st.phase     = PH_RESET_WAIT;
                        seq_st.wait_left = RST_DLY_MS;
                    end
                    default: ;
                endcase
            end
        endcase
        if (emit)
        begin
            outstanding_reports.push_back(res);
            reports_due++;
        end
        acted = emit || (seq_st != prev);
    endtask

    // ------------------------------------------------------------------------
    // Report checker: every accepted result word against the oldest report
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input longint want_v, input longint got_v);
        if (want_v != got_v)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, want_v, got_v);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got                   = '0;
            got.out_kind          = kind_t'(m_axis_tuser);
            got.bus_addr          = m_axis_tdata[6:0];
            got.write_len         = m_axis_tdata[8:7];
            got.write_bytes       = m_axis_tdata[32:9];
            got.read_len          = m_axis_tdata[35:33];
            got.no_stop           = m_axis_tdata[36];
            got.humidity_centi    = m_axis_tdata[50:37];
            got.temperature_centi = m_axis_tdata[65:51];
            if (outstanding_reports.size() == 0)
            begin
                $display("%0t ns: unexpected result word, expected nothing, actual %h/%h",
                         $time, m_axis_tuser, m_axis_tdata);
                error_count++;
            end
            else
            begin
                want = outstanding_reports.pop_front();
                check_field("out_kind", want.out_kind, got.out_kind);
                check_field("bus_addr", want.bus_addr, got.bus_addr);
                check_field("write_len", want.write_len, got.write_len);
                check_field("write_bytes", want.write_bytes, got.write_bytes);
                check_field("read_len", want.read_len, got.read_len);
                check_field("no_stop", want.no_stop, got.no_stop);
                check_field("humidity_centi", want.humidity_centi, got.humidity_centi);
                check_field("temperature_centi",
                            longint'($signed(want.temperature_centi)),
                            longint'($signed(got.temperature_centi)));
                kinds_seen[int'(want.out_kind)]++;
                reports_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Shared drivers. All start and end on a falling edge.
    // ------------------------------------------------------------------------
    function automatic logic [47:0] random48();
        return {16'($urandom()), 32'($urandom())};
    endfunction

    // offer one word, wait for the handshake, then track it
    task automatic send_word(input op_t op, input logic [47:0] rb);
        bit acted;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= rb;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sequence_step(op, rb, acted);
        words_sent++;
        if (acted)
            words_acted++;
        @(negedge clk);
    endtask

    // the word a well-behaved bus master and timer would send next;
    // status bits are steered by the two percentages
    task automatic advance_sequence(input int cal_pct, input int busy_pct);
        logic [47:0] rb;
        rb = random48();
        case (seq_st.phase)
            PH_STATUS_POLL:
            begin
                rb[40 + STAT_CAL_BIT] = ($urandom_range(99) < cal_pct);
                send_word(OP_XFER_DONE, rb);
            end
            PH_BUSY_POLL:
            begin
                rb[40 + STAT_BUSY_BIT] = ($urandom_range(99) < busy_pct);
                send_word(OP_XFER_DONE, rb);
            end
            PH_CAL_WAIT, PH_MEAS_WAIT, PH_BUSY_WAIT, PH_RESET_WAIT:
                send_word(OP_TICK, rb);
            default:
                send_word(OP_XFER_DONE, rb);
        endcase
    endtask

    task automatic run_to_idle(input int cal_pct, input int busy_pct);
        while (seq_st.phase != PH_IDLE)
            advance_sequence(cal_pct, busy_pct);
    endtask

    // full measurement with given raw data; optional single busy retry
    task automatic measure_with_raw(input logic [39:0] raw, input bit busy_once);
        send_word(OP_START_MEAS, random48());
        while (seq_st.phase != PH_DATA && seq_st.phase != PH_IDLE)
            advance_sequence(100, (busy_once && !seq_st.busy_retried) ? 100 : 0);
        if (seq_st.phase == PH_DATA)
            send_word(OP_XFER_DONE, {8'($urandom_range(255)), raw});
    endtask

    // stop sending, let all reports drain, then let the pipeline empty
    task automatic settle();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        while (outstanding_reports.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        if (outstanding_reports.size() != 0)
        begin
            $display("%0t ns: %0d result words never arrived, expected %0d more, actual 0",
                     $time, outstanding_reports.size(), outstanding_reports.size());
            error_count++;
            outstanding_reports.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // only called with the block settled
    task automatic cfg_write(input logic idx, input logic [9:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_DEV_ADDR)
            sensor_addr = value[6:0];
        else
            calib_budget_ms = value;
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // reset values, ignored words, soft reset, measurement at the low data extreme
    task automatic test_defaults();
        send_word(OP_TICK, random48());             // idle: nothing
        send_word(OP_XFER_DONE, random48());        // nothing outstanding
        send_word(OP_START_RESET, random48());
        send_word(OP_START_RESET, random48());      // busy: ignored
        send_word(OP_START_MEAS, random48());       // busy: ignored
        run_to_idle(100, 0);
        measure_with_raw(40'h00_0000_0000, 1'b0);   // 0 %RH, -50.00 C
    endtask

    // calibration retries until the budget runs out, zero and minimum budget
    task automatic test_calibration_budget();
        settle();
        cfg_write(REG_DEV_ADDR, 10'd0);
        cfg_write(REG_CALIB_TIMEOUT, 10'd25);
        send_word(OP_START_MEAS, random48());
        run_to_idle(0, 0);                          // polls at 0, 10, 20 ms
        settle();
        cfg_write(REG_DEV_ADDR, 10'd127);
        cfg_write(REG_CALIB_TIMEOUT, 10'd0);
        send_word(OP_START_MEAS, random48());       // times out at once
        settle();
        cfg_write(REG_CALIB_TIMEOUT, 10'd1);
        send_word(OP_START_MEAS, random48());
        send_word(OP_START_RESET, random48());      // busy: ignored
        run_to_idle(0, 0);
        settle();
        cfg_write(REG_CALIB_TIMEOUT, 10'd1000);
    endtask

    // busy once then ready (high data extreme), then busy twice
    task automatic test_busy_retry();
        measure_with_raw(40'hFF_FFFF_FFFF, 1'b1);   // 99.99 %RH, 149.99 C
        send_word(OP_START_MEAS, random48());
        run_to_idle(100, 100);
    endtask

    // receiver holds off while every word yields a report
    task automatic test_output_backpressure();
        settle();
        cfg_write(REG_CALIB_TIMEOUT, 10'd0);
        hold_request = 1;
        repeat (24) send_word(OP_START_MEAS, random48());
    endtask

    // random readout traffic with mostly well-formed sequences
    task automatic test_random_traffic(input int src_pct, input int snk_pct,
                                       input logic [9:0] addr, input logic [9:0] budget,
                                       input int n_words);
        int acted_start;
        int due_start;
        int pick;
        settle();
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        cfg_write(REG_DEV_ADDR, addr);
        cfg_write(REG_CALIB_TIMEOUT, budget);
        acted_start = words_acted;
        due_start   = reports_due;
        while (words_acted - acted_start < n_words || reports_due - due_start < 3)
        begin
            pick = $urandom_range(99);
            if (seq_st.phase == PH_IDLE)
            begin
                if (pick < 60)
                    send_word(OP_START_MEAS, random48());
                else if (pick < 80)
                    send_word(OP_START_RESET, random48());
                else
                    send_word(op_t'($urandom_range(3)), random48());
            end
            else if (pick < 6)
                send_word(op_t'($urandom_range(3)), random48());   // noise
            else
                advance_sequence(60, 35);
        end
        run_to_idle(60, 35);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_defaults();
        test_calibration_budget();
        test_busy_retry();
        test_output_backpressure();
        test_random_traffic(15, 51, 10'($urandom_range(127)), 10'($urandom_range(1, 60)), 12);
        test_random_traffic(51, 15, 10'd56, 10'($urandom_range(1, 1000)), 12);
        test_random_traffic(0, 0, 10'($urandom_range(127)), 10'($urandom_range(20, 200)), 12);
        settle();

        $display("Run covered %0d words (%0d changing state), %0d result words checked:",
                 words_sent, words_acted, reports_checked);
        $display("  %0d bus requests, %0d measurements, %0d reset reports,",
                 kinds_seen[KIND_REQ], kinds_seen[KIND_MEAS], kinds_seen[KIND_RESET_DONE]);
        $display("  %0d/%0d cal/busy timeouts",
                 kinds_seen[KIND_CALIB_TO], kinds_seen[KIND_BUSY_TO]);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
